>>> rtl/inorder_delivery_reorder_window_assert.svh
// Assertion macros for the checker file of the reorder window.
// No dependencies; include with the bare file name.
`ifndef INORDER_DELIVERY_REORDER_WINDOW_ASSERT_SVH
`define INORDER_DELIVERY_REORDER_WINDOW_ASSERT_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define IDRW_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define IDRW_ASSERT(label, prop, msg) \
   `IDRW_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

>>> rtl/idrw_pkg.sv
// Shared types and constants for the in-order delivery reorder window.
// No dependencies; used through scoped names by every rtl file but idrw_ram and the assert header.
package idrw_pkg;

   localparam int INST_W   = 32;
   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 16;
   localparam int ENTRY_W  = KEY_W + HANDLE_W + SIZE_W;

   typedef enum logic {
      OP_MAP    = 1'b0,
      OP_ACCEPT = 1'b1
   } opcode_type;

   typedef enum logic {
      KIND_DELIVERY = 1'b0,
      KIND_STATUS   = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      DISP_FUTURE       = 3'd0,
      DISP_OLD          = 3'd1,
      DISP_STORED       = 3'd2,
      DISP_DONE_ALREADY = 3'd3,
      DISP_REPLACED     = 3'd4,
      DISP_DROPPED      = 3'd5,
      DISP_DISCARDED    = 3'd6,
      DISP_COMPLETED    = 3'd7
   } disp_type;

   // flag update for one slot
   typedef struct packed {
      logic set_map;
      logic set_fin;
      logic clr_map;
      logic clr_fin;
   } flag_op_type;

endpackage

>>> rtl/idrw_req_if.sv
// Input channel of the reorder window: valid/ready plus one map or acceptance item.
// Depends on idrw_pkg for field widths.
interface idrw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [idrw_pkg::INST_W-1:0]   instance_req;
   logic [idrw_pkg::KEY_W-1:0]    command_key;
   logic [idrw_pkg::HANDLE_W-1:0] payload_handle;
   logic [idrw_pkg::SIZE_W-1:0]   payload_size;

   modport source (output valid, opcode, instance_req, command_key, payload_handle,
                   payload_size, input ready);
   modport sink   (input valid, opcode, instance_req, command_key, payload_handle,
                   payload_size, output ready);
endinterface

>>> rtl/idrw_rsp_if.sv
// Result channel of the reorder window: valid/ready plus one delivery or status item.
// Depends on idrw_pkg for field widths.
interface idrw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [idrw_pkg::INST_W-1:0]   delivered_instance;
   logic [idrw_pkg::KEY_W-1:0]    delivered_key;
   logic [idrw_pkg::HANDLE_W-1:0] delivered_handle;
   logic [idrw_pkg::SIZE_W-1:0]   delivered_size;
   logic [2:0]                    disposition;
   logic                          last;

   modport source (output valid, kind, delivered_instance, delivered_key, delivered_handle,
                   delivered_size, disposition, last, input ready);
   modport sink   (input valid, kind, delivered_instance, delivered_key, delivered_handle,
                   delivered_size, disposition, last, output ready);
endinterface

>>> rtl/idrw_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module idrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/idrw_flags.sv
// Per-slot mapping-known and final-known flags, cleared by reset.
// Depends on idrw_pkg (flag_op_type).
module idrw_flags #(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  idrw_pkg::flag_op_type    op,
   output logic                     map_known,
   output logic                     fin_known
);

   logic [DEPTH-1:0] map_ff, map_in;
   logic [DEPTH-1:0] fin_ff, fin_in;

   always_comb begin
      map_in = map_ff;
      fin_in = fin_ff;
      if (op.set_map) map_in[addr] = 1'b1;
      if (op.clr_map) map_in[addr] = 1'b0;
      if (op.set_fin) fin_in[addr] = 1'b1;
      if (op.clr_fin) fin_in[addr] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
         fin_ff <= '0;
      end else begin
         map_ff <= map_in;
         fin_ff <= fin_in;
      end
   end

   assign map_known = map_ff[addr];
   assign fin_known = fin_ff[addr];

endmodule

>>> rtl/inorder_delivery_reorder_window.sv
// In-order delivery reorder window: top level, sequencer and slot datapath.
// Depends on idrw_pkg, idrw_req_if, idrw_rsp_if, idrw_ram and idrw_flags.
//
// Usage:
//  - req_chan carries command mappings (opcode 0) and final-key acceptances
//    (opcode 1) for consensus instances; a transfer happens when valid and
//    ready are both high. One item is worked on at a time.
//  - rsp_chan returns zero or more deliveries (kind 0, instance order) and then
//    exactly one status transfer (kind 1, last 1) per input item.
//  - csr_wr_en/csr_wr_data write the anchor bit (1: the first item after reset
//    puts the cursor just below its instance); write it only while idle.
//  - Each input item passes ST_IDLE, ST_LOOKUP and ST_STATUS when outside the
//    window, with ST_MODIFY before ST_STATUS when inside; an item that
//    completes a slot adds ST_DEL_CHECK and ST_DEL_EMIT per delivered
//    instance and a last ST_DEL_CHECK. An in-window item reads its slot RAM
//    entry in ST_LOOKUP and may write it back in ST_MODIFY; a delivery burst
//    walks one slot at a time (flag check and RAM read, then the output load).
//  - Reset (synchronous) clears all flags, the cursor and the anchor bit, and
//    arms the first-item anchor. No clearing pass: the RAM needs none.
//  - A stalled receiver holds the output register; the sequencer waits, and
//    the next request is taken once the status item sits in the output
//    register, even if it has not been transferred yet.
module inorder_delivery_reorder_window #(
   parameter int WINDOW_DEPTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data,
   idrw_req_if.sink      req_chan,
   idrw_rsp_if.source    rsp_chan
);

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int IW     = idrw_pkg::INST_W;
   localparam int KW     = idrw_pkg::KEY_W;
   localparam int HW     = idrw_pkg::HANDLE_W;
   localparam int SW     = idrw_pkg::SIZE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MODIFY,
      ST_DEL_CHECK,
      ST_DEL_EMIT,
      ST_STATUS
   } state_type;

   // sequencer state and per-item registers
   state_type          state_ff, state_in;
   logic               anchor_first_ff, anchor_first_in;
   logic               start_pending_ff, start_pending_in;
   logic [IW-1:0]      cursor_ff, cursor_in;
   logic [SLOT_W-1:0]  cursor_slot_ff, cursor_slot_in;
   logic               op_ff, op_in;
   logic [IW-1:0]      inst_ff, inst_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [HW-1:0]      handle_ff, handle_in;
   logic [SW-1:0]      size_ff, size_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   idrw_pkg::disp_type disp_ff, disp_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   idrw_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic [IW-1:0]      rsp_inst_ff, rsp_inst_in;
   logic [KW-1:0]      rsp_key_ff, rsp_key_in;
   logic [HW-1:0]      rsp_handle_ff, rsp_handle_in;
   logic [SW-1:0]      rsp_size_ff, rsp_size_in;
   idrw_pkg::disp_type rsp_disp_ff, rsp_disp_in;
   logic               rsp_last_ff, rsp_last_in;

   // window check and slot arithmetic
   logic [IW:0]        window_end;
   logic               is_future;
   logic               is_old;
   logic [IW-1:0]      inst_diff;
   logic [SLOT_W:0]    slot_sum;
   logic [SLOT_W-1:0]  lookup_slot;
   logic [SLOT_W-1:0]  next_slot;
   logic               out_free;

   // slot RAM and flag store hookup
   logic                          ram_wr_en;
   logic [idrw_pkg::ENTRY_W-1:0]  ram_wr_data;
   logic                          ram_rd_en;
   logic [SLOT_W-1:0]             ram_rd_addr;
   logic [idrw_pkg::ENTRY_W-1:0]  ram_rd_data;
   logic [KW-1:0]                 rd_key;
   logic [HW-1:0]                 rd_handle;
   logic [SW-1:0]                 rd_size;
   logic [SLOT_W-1:0]             flag_addr;
   idrw_pkg::flag_op_type         flag_op;
   logic                          map_known;
   logic                          fin_known;

   idrw_ram #(
      .WIDTH (idrw_pkg::ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   idrw_flags #(
      .DEPTH (WINDOW_DEPTH)
   ) u_flags (
      .clock     (clock),
      .reset     (reset),
      .addr      (flag_addr),
      .op        (flag_op),
      .map_known (map_known),
      .fin_known (fin_known)
   );

   assign {rd_key, rd_handle, rd_size} = ram_rd_data;

   // Window bounds, compared without wrap-around.
   assign window_end = {1'b0, cursor_ff} + (IW+1)'(WINDOW_DEPTH);
   assign is_future  = {1'b0, inst_ff} >= window_end;
   assign is_old     = inst_ff <= cursor_ff;

   // Slots are numbered relative to the cursor: only differences inside the
   // window matter, so instance cursor+d lives at cursor_slot+d (mod depth).
   // In the window d < depth, so one compare-subtract wraps the sum.
   assign inst_diff = inst_ff - cursor_ff;
   assign slot_sum  = {1'b0, cursor_slot_ff} + {1'b0, inst_diff[SLOT_W-1:0]};
   assign lookup_slot = (slot_sum >= (SLOT_W+1)'(WINDOW_DEPTH))
                      ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_DEPTH))
                      : slot_sum[SLOT_W-1:0];

   assign next_slot = (cursor_slot_ff == SLOT_W'(WINDOW_DEPTH - 1))
                    ? '0 : cursor_slot_ff + SLOT_W'(1);

   // Output register may take a new item when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign flag_addr = (state_ff == ST_MODIFY) ? slot_ff : next_slot;

   always_comb begin
      state_in         = state_ff;
      anchor_first_in  = anchor_first_ff;
      start_pending_in = start_pending_ff;
      cursor_in        = cursor_ff;
      cursor_slot_in   = cursor_slot_ff;
      op_in            = op_ff;
      inst_in          = inst_ff;
      key_in           = key_ff;
      handle_in        = handle_ff;
      size_in          = size_ff;
      slot_in          = slot_ff;
      disp_in          = disp_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_inst_in   = rsp_inst_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_disp_in   = rsp_disp_ff;
      rsp_last_in   = rsp_last_ff;

      ram_wr_en   = 1'b0;
      ram_wr_data = {rd_key, rd_handle, rd_size};
      ram_rd_en   = 1'b0;
      ram_rd_addr = next_slot;
      flag_op     = '0;

      if (csr_wr_en) begin
         anchor_first_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.opcode;
               inst_in   = req_chan.instance_req;
               key_in    = req_chan.command_key;
               handle_in = req_chan.payload_handle;
               size_in   = req_chan.payload_size;
               // first item after reset may set the starting point
               if (start_pending_ff) begin
                  start_pending_in = 1'b0;
                  if (anchor_first_ff) begin
                     cursor_in = req_chan.instance_req - IW'(1);
                  end
               end
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            if (is_future) begin
               disp_in  = idrw_pkg::DISP_FUTURE;
               state_in = ST_STATUS;
            end else if (is_old) begin
               disp_in  = idrw_pkg::DISP_OLD;
               state_in = ST_STATUS;
            end else begin
               slot_in     = lookup_slot;
               ram_rd_en   = 1'b1;
               ram_rd_addr = lookup_slot;
               state_in    = ST_MODIFY;
            end
         end

         ST_MODIFY: begin
            // read-modify-write of the slot; flags and RAM data both current
            state_in = ST_STATUS;
            if (map_known && fin_known) begin
               disp_in = idrw_pkg::DISP_DONE_ALREADY;
            end else if (op_ff == idrw_pkg::OP_MAP) begin
               if (map_known) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {key_ff, handle_ff, size_ff};
                  disp_in     = idrw_pkg::DISP_REPLACED;
               end else if (fin_known) begin
                  if (rd_key == key_ff) begin
                     ram_wr_en       = 1'b1;
                     ram_wr_data     = {rd_key, handle_ff, size_ff};
                     flag_op.set_map = 1'b1;
                     disp_in         = idrw_pkg::DISP_COMPLETED;
                     state_in        = ST_DEL_CHECK;
                  end else begin
                     disp_in = idrw_pkg::DISP_DROPPED;
                  end
               end else begin
                  ram_wr_en       = 1'b1;
                  ram_wr_data     = {key_ff, handle_ff, size_ff};
                  flag_op.set_map = 1'b1;
                  disp_in         = idrw_pkg::DISP_STORED;
               end
            end else begin
               if (map_known) begin
                  if (rd_key == key_ff) begin
                     flag_op.set_fin = 1'b1;
                     disp_in         = idrw_pkg::DISP_COMPLETED;
                     state_in        = ST_DEL_CHECK;
                  end else begin
                     // conflicting final key: drop the mapping, keep the key
                     ram_wr_en       = 1'b1;
                     ram_wr_data     = {key_ff, rd_handle, rd_size};
                     flag_op.clr_map = 1'b1;
                     flag_op.set_fin = 1'b1;
                     disp_in         = idrw_pkg::DISP_DISCARDED;
                  end
               end else if (fin_known) begin
                  disp_in = idrw_pkg::DISP_DONE_ALREADY;
               end else begin
                  ram_wr_en       = 1'b1;
                  ram_wr_data     = {key_ff, rd_handle, rd_size};
                  flag_op.set_fin = 1'b1;
                  disp_in         = idrw_pkg::DISP_STORED;
               end
            end
         end

         ST_DEL_CHECK: begin
            // next slot complete and cursor not at its top: fetch it
            if (cursor_ff != '1 && map_known && fin_known) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_slot;
               state_in    = ST_DEL_EMIT;
            end else begin
               state_in = ST_STATUS;
            end
         end

         ST_DEL_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = idrw_pkg::KIND_DELIVERY;
               rsp_inst_in     = cursor_ff + IW'(1);
               rsp_key_in      = rd_key;
               rsp_handle_in   = rd_handle;
               rsp_size_in     = rd_size;
               rsp_disp_in     = idrw_pkg::DISP_FUTURE;
               rsp_last_in     = 1'b0;
               flag_op.clr_map = 1'b1;
               flag_op.clr_fin = 1'b1;
               cursor_in       = cursor_ff + IW'(1);
               cursor_slot_in  = next_slot;
               state_in        = ST_DEL_CHECK;
            end
         end

         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = idrw_pkg::KIND_STATUS;
               rsp_inst_in   = '0;
               rsp_key_in    = '0;
               rsp_handle_in = '0;
               rsp_size_in   = '0;
               rsp_disp_in   = disp_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         anchor_first_ff  <= 1'b0;
         start_pending_ff <= 1'b1;
         cursor_ff        <= '0;
         cursor_slot_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         anchor_first_ff  <= anchor_first_in;
         start_pending_ff <= start_pending_in;
         cursor_ff        <= cursor_in;
         cursor_slot_ff   <= cursor_slot_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      op_ff         <= op_in;
      inst_ff       <= inst_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      size_ff       <= size_in;
      slot_ff       <= slot_in;
      disp_ff       <= disp_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_inst_ff   <= rsp_inst_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_disp_ff   <= rsp_disp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.kind               = rsp_kind_ff;
   assign rsp_chan.delivered_instance = rsp_inst_ff;
   assign rsp_chan.delivered_key      = rsp_key_ff;
   assign rsp_chan.delivered_handle   = rsp_handle_ff;
   assign rsp_chan.delivered_size     = rsp_size_ff;
   assign rsp_chan.disposition        = rsp_disp_ff;
   assign rsp_chan.last               = rsp_last_ff;

endmodule

>>> rtl/idrw_checker.sv
// Port-level checker for the reorder window, bound to the top level.
// Depends on idrw_pkg and inorder_delivery_reorder_window_assert.svh.
`include "inorder_delivery_reorder_window_assert.svh"

module idrw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [31:0] rsp_inst,
   input logic [31:0] rsp_key,
   input logic [2:0]  rsp_disp,
   input logic        rsp_last
);

   // a stalled result keeps its contents
   `IDRW_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inst) && $stable(rsp_key) && $stable(rsp_disp) && $stable(rsp_kind), "rsp changed while stalled")

   // one item at a time: no request right after a transfer
   `IDRW_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready, "request taken while busy")

   // deliveries always precede the status, so no new request meanwhile
   `IDRW_ASSERT(a_delivery_busy, rsp_valid && rsp_kind == idrw_pkg::KIND_DELIVERY |-> !req_ready, "request open during delivery")

   // status items carry last and a zero instance; deliveries never do
   `IDRW_ASSERT(a_kind_last, rsp_valid |-> (rsp_last == (rsp_kind == idrw_pkg::KIND_STATUS)) && ((rsp_kind == idrw_pkg::KIND_STATUS) == (rsp_inst == 32'd0)), "kind and last disagree")

endmodule

bind inorder_delivery_reorder_window idrw_checker u_idrw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.kind),
   .rsp_inst  (rsp_chan.delivered_instance),
   .rsp_key   (rsp_chan.delivered_key),
   .rsp_disp  (rsp_chan.disposition),
   .rsp_last  (rsp_chan.last)
);

>>> tb/tb_inorder_delivery_reorder_window.sv
// Self-checking testbench for the in-order delivery reorder window.
// Depends on idrw_pkg, idrw_req_if, idrw_rsp_if and the rtl top; reads no files.
// Each accepted request runs through an in-bench window model; result transfers
// are checked in order.
module tb_inorder_delivery_reorder_window;
   import idrw_pkg::*;

   localparam int          WIN         = 32;
   localparam logic [31:0] TOP         = 32'hFFFF_FFFF;
   localparam int          CYCLE_LIMIT = 500_000;
   // idle settle: slack after the owed results have drained
   localparam int          SETTLE      = 8;

   typedef enum int {RX_STEADY, RX_PATTERN, RX_COIN} rx_mode_type;

   // one result transfer as the window should emit it
   typedef struct {
      kind_type    kind;
      logic [31:0] inst;
      logic [31:0] key;
      logic [31:0] handle;
      logic [15:0] size;
      disp_type    disp;
      logic        last;
   } window_out_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   idrw_req_if req_bus();
   idrw_rsp_if rsp_bus();

   inorder_delivery_reorder_window #(.WINDOW_DEPTH(WIN)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // window model state, mirrors the slot store and delivery cursor
   // ---------------------------------------------------------------
   bit          map_known   [WIN];
   bit          fin_known   [WIN];
   logic [31:0] slot_key    [WIN];
   logic [31:0] slot_handle [WIN];
   logic [15:0] slot_size   [WIN];
   logic [31:0] cursor;
   bit          first_pending;
   bit          anchor_first_reg;

   window_out_type owed_outputs [$];   // results still to come, oldest first

   int          mismatches;
   int          cycle_count;
   int          in_window_items;
   int          ignored_items;
   int          deliveries_seen;
   int          widest_burst;
   int          burst_left;
   int          gap_max;
   rx_mode_type rx_mode    = RX_STEADY;
   logic [7:0]  rx_pattern = 8'b1011_0010;

   function automatic int slot_of(logic [31:0] inst);
      return int'(inst % WIN);
   endfunction

   function automatic void owe(kind_type kind, logic [31:0] inst, key, handle,
                               logic [15:0] size, disp_type disp);
      window_out_type o;
      o.kind   = kind;
      o.inst   = inst;
      o.key    = key;
      o.handle = handle;
      o.size   = size;
      o.disp   = disp;
      o.last   = (kind == KIND_STATUS);
      owed_outputs.push_back(o);
   endfunction

   // walk forward from the cursor while the next slot is complete
   function automatic void release_complete_run();
      logic [31:0] nxt;
      int          s;
      int          n;
      n = 0;
      while (cursor != TOP) begin
         nxt = cursor + 1;
         s   = slot_of(nxt);
         if (!(map_known[s] && fin_known[s])) break;
         // disposition reads zero on deliveries
         owe(KIND_DELIVERY, nxt, slot_key[s], slot_handle[s], slot_size[s], DISP_FUTURE);
         map_known[s] = 1'b0;
         fin_known[s] = 1'b0;
         cursor       = nxt;
         n++;
      end
      if (n > widest_burst) widest_burst = n;
   endfunction

   // predicted effect of one accepted request
   function automatic void apply_to_window(opcode_type op, logic [31:0] inst, key, handle,
                                           logic [15:0] size);
      int       s;
      disp_type disp;
      if (first_pending) begin
         if (anchor_first_reg) cursor = inst - 1;
         first_pending = 1'b0;
      end
      // bounds are compared without wrap-around
      if ({1'b0, inst} >= {1'b0, cursor} + 33'(WIN)) begin
         disp = DISP_FUTURE;
      end else if (inst <= cursor) begin
         disp = DISP_OLD;
      end else begin
         s = slot_of(inst);
         in_window_items++;
         if (map_known[s] && fin_known[s]) begin
            disp = DISP_DONE_ALREADY;
         end else if (op == OP_MAP) begin
            if (map_known[s]) begin
               // overwritten even when the key is unchanged
               slot_key[s]    = key;
               slot_handle[s] = handle;
               slot_size[s]   = size;
               disp           = DISP_REPLACED;
            end else if (fin_known[s]) begin
               if (slot_key[s] == key) begin
                  slot_handle[s] = handle;
                  slot_size[s]   = size;
                  map_known[s]   = 1'b1;
                  disp           = DISP_COMPLETED;
                  release_complete_run();
               end else begin
                  disp = DISP_DROPPED;
               end
            end else begin
               slot_key[s]    = key;
               slot_handle[s] = handle;
               slot_size[s]   = size;
               map_known[s]   = 1'b1;
               disp           = DISP_STORED;
            end
         end else begin
            if (map_known[s]) begin
               if (slot_key[s] == key) begin
                  fin_known[s] = 1'b1;
                  disp         = DISP_COMPLETED;
                  release_complete_run();
               end else begin
                  // final key wins, the stale mapping goes
                  map_known[s] = 1'b0;
                  slot_key[s]  = key;
                  fin_known[s] = 1'b1;
                  disp         = DISP_DISCARDED;
               end
            end else if (fin_known[s]) begin
               disp = DISP_DONE_ALREADY;
            end else begin
               slot_key[s]  = key;
               fin_known[s] = 1'b1;
               disp         = DISP_STORED;
            end
         end
      end
      if (disp == DISP_FUTURE || disp == DISP_OLD) ignored_items++;
      owe(KIND_STATUS, '0, '0, '0, '0, disp);
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------
   task automatic report(string what);
      mismatches++;
      $display("[cycle %0d] MISMATCH %s", cycle_count, what);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s: got %h, want %h", name, got, want));
   endtask

   // every result transfer is matched against the oldest owed result
   always @(posedge clock) begin
      window_out_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (owed_outputs.size() == 0) begin
            report($sformatf("result transfer with nothing owed (kind %0d inst %h disp %0d)",
                             rsp_bus.kind, rsp_bus.delivered_instance, rsp_bus.disposition));
         end else begin
            want = owed_outputs.pop_front();
            check_field("kind", rsp_bus.kind, want.kind);
            check_field("delivered_instance", rsp_bus.delivered_instance, want.inst);
            check_field("delivered_key", rsp_bus.delivered_key, want.key);
            check_field("delivered_handle", rsp_bus.delivered_handle, want.handle);
            check_field("delivered_size", rsp_bus.delivered_size, want.size);
            check_field("disposition", rsp_bus.disposition, want.disp);
            check_field("last", rsp_bus.last, want.last);
            if (want.kind == KIND_DELIVERY) deliveries_seen++;
         end
      end
   end

   // receiver: always ready, a rotating stall pattern, or a coin toss
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_STEADY:  rsp_bus.ready <= 1'b1;
            RX_PATTERN: rsp_bus.ready <= rx_pattern[0];
            default:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
      if (cycle_count % 256 == 0) begin
         rx_pattern <= 8'($urandom_range(1, 255));
      end else begin
         rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results owed", cycle_count,
                  owed_outputs.size());
         $display("** inorder_delivery_reorder_window: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   function automatic logic [15:0] rand_size();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic pick_pace();
      case ($urandom_range(0, 2))
         0:       gap_max = 0;
         1:       gap_max = 3;
         default: gap_max = 8;
      endcase
      rx_mode = rx_mode_type'($urandom_range(0, 2));
   endtask

   // One request transfer. Sender runs in bursts; a gap drops valid and puts
   // junk on the payload. After the transfer valid stays up, so the next call in
   // the same step keeps it high; wait_idle lowers it otherwise.
   task automatic send_item(opcode_type op, logic [31:0] inst, key, handle,
                            logic [15:0] size);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
         if (gap != 0) begin
            req_bus.valid          <= 1'b0;
            req_bus.opcode         <= 1'($urandom_range(0, 1));
            req_bus.instance_req   <= $urandom;
            req_bus.command_key    <= $urandom;
            req_bus.payload_handle <= $urandom;
            req_bus.payload_size   <= 16'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= op;
      req_bus.instance_req   <= inst;
      req_bus.command_key    <= key;
      req_bus.payload_handle <= handle;
      req_bus.payload_size   <= size;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_to_window(op, inst, key, handle, size);
      burst_left--;
   endtask

   // park the sender and let every owed result drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (owed_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_anchor_first(logic value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      anchor_first_reg = value;
      csr_wr_en   <= 1'b0;
   endtask

   // bring one instance to complete, whatever its slot already holds
   task automatic complete_instance(logic [31:0] inst);
      int          s;
      logic [31:0] key;
      s = slot_of(inst);
      if (map_known[s] && fin_known[s]) begin
         send_item(OP_ACCEPT, inst, slot_key[s], $urandom, rand_size());
      end else if (fin_known[s]) begin
         send_item(OP_MAP, inst, slot_key[s], $urandom, rand_size());
      end else if (map_known[s]) begin
         send_item(OP_ACCEPT, inst, slot_key[s], $urandom, rand_size());
      end else begin
         key = $urandom;
         if ($urandom_range(0, 1)) begin
            send_item(OP_MAP, inst, key, $urandom, rand_size());
            send_item(OP_ACCEPT, inst, key, $urandom, rand_size());
         end else begin
            send_item(OP_ACCEPT, inst, key, $urandom, rand_size());
            send_item(OP_MAP, inst, key, $urandom, rand_size());
         end
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // anchor armed before the first item: cursor lands just below it
   task automatic test_anchor_entry();
      logic [31:0] first;
      logic [31:0] key;
      write_anchor_first(1'b0);
      write_anchor_first(1'b1);
      // leave room below the top for the rest of the run
      first = TOP - 150 - $urandom_range(0, 20);
      key   = $urandom;
      send_item(OP_MAP, first, key, 32'hFFFF_FFFF, 16'h0000);
      send_item(OP_ACCEPT, first, key, 32'h0000_0000, 16'hFFFF);
   endtask

   // old and future items on both sides, both edges of the window
   task automatic test_window_edges();
      logic [31:0] c;
      c = cursor;
      send_item(OP_MAP, c, $urandom, $urandom, rand_size());
      send_item(OP_ACCEPT, 32'h0000_0000, $urandom, $urandom, rand_size());
      send_item(OP_MAP, 32'h0000_0001, $urandom, $urandom, rand_size());
      send_item(OP_ACCEPT, c + 32, $urandom, $urandom, rand_size());
      send_item(OP_MAP, TOP, $urandom, $urandom, rand_size());
      send_item(OP_MAP, c + 31, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      send_item(OP_MAP, c + 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
   endtask

   // every slot update path, out-of-order completion, then a run of three
   task automatic test_slot_updates();
      logic [31:0] c, k1, k2, k3, k4;
      c  = cursor;
      k1 = $urandom;
      k2 = ~k1;
      k3 = k1 ^ 32'h8000_0001;
      k4 = k3 + 32'd1;
      send_item(OP_MAP, c + 2, k1, $urandom, rand_size());      // stored
      send_item(OP_MAP, c + 2, k1, $urandom, rand_size());      // replaced, same key
      send_item(OP_MAP, c + 2, k2, $urandom, rand_size());      // replaced
      send_item(OP_ACCEPT, c + 2, k3, $urandom, rand_size());   // mapping discarded
      send_item(OP_MAP, c + 2, k4, $urandom, rand_size());      // dropped vs final key
      send_item(OP_ACCEPT, c + 2, k4, $urandom, rand_size());   // final already known
      send_item(OP_MAP, c + 2, k3, $urandom, rand_size());      // complete, not next
      send_item(OP_ACCEPT, c + 2, k3, $urandom, rand_size());   // already complete
      send_item(OP_ACCEPT, c + 3, k1, $urandom, rand_size());   // final stored first
      send_item(OP_MAP, c + 3, k1, $urandom, rand_size());      // complete, not next
      send_item(OP_ACCEPT, c + 1, 32'hFFFF_FFFF, $urandom, rand_size());  // run of three
   endtask

   // Mostly well-formed map/accept pairs near the cursor, plus single pokes
   // with matching or clashing keys, old/future items and raw noise. The
   // register write up front lands long after the first item and must not
   // move the cursor.
   task automatic test_random_traffic(logic anchor_value);
      int          start_hits;
      int          iter;
      int          pick;
      int          s;
      logic [31:0] inst;
      logic [31:0] key;
      write_anchor_first(anchor_value);
      start_hits = in_window_items;
      iter       = 0;
      while (in_window_items - start_hits < 150 && cursor < TOP - 64) begin
         if (iter % 40 == 0) pick_pace();
         iter++;
         pick = $urandom_range(0, 99);
         inst = cursor + 1 + (($urandom_range(0, 2) != 0) ? $urandom_range(0, 3)
                                                          : $urandom_range(0, 30));
         if (pick < 60) begin
            complete_instance(inst);
         end else if (pick < 82) begin
            s   = slot_of(inst);
            key = $urandom;
            if ((map_known[s] || fin_known[s]) && $urandom_range(0, 1)) key = slot_key[s];
            send_item(opcode_type'($urandom_range(0, 1)), inst, key, $urandom, rand_size());
         end else if (pick < 92) begin
            inst = $urandom_range(0, 1) ? cursor - $urandom_range(0, 3)
                                        : cursor + 32 + $urandom_range(0, 40);
            send_item(opcode_type'($urandom_range(0, 1)), inst, $urandom, $urandom,
                      rand_size());
         end else begin
            send_item(opcode_type'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                      16'($urandom));
         end
      end
   endtask

   // Drive the cursor to 2^32-1 in chunks of up to 31: fill the far slots,
   // then finish the next one so a full window drains in one run. Once
   // pinned at the top every item is old.
   task automatic test_cursor_top();
      logic [31:0] base;
      int          span;
      pick_pace();
      while (cursor != TOP) begin
         base = cursor;
         span = (TOP - base > 31) ? 31 : int'(TOP - base);
         for (int k = span; k >= 2; k--) complete_instance(base + k);
         complete_instance(base + 1);
      end
      send_item(OP_MAP, TOP, $urandom, $urandom, rand_size());
      send_item(OP_ACCEPT, 32'h0000_0000, $urandom, $urandom, rand_size());
      send_item(OP_MAP, $urandom, $urandom, $urandom, rand_size());
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------
   initial begin
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_wr_data            <= 1'b0;
      req_bus.valid          <= 1'b0;
      req_bus.opcode         <= 1'b0;
      req_bus.instance_req   <= '0;
      req_bus.command_key    <= '0;
      req_bus.payload_handle <= '0;
      req_bus.payload_size   <= '0;
      cursor           = '0;
      first_pending    = 1'b1;
      anchor_first_reg = 1'b0;
      burst_left       = 0;
      gap_max          = 3;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_anchor_entry();
      test_window_edges();
      test_slot_updates();
      test_random_traffic(1'b0);
      test_random_traffic(1'b1);
      test_cursor_top();
      wait_idle();

      $display("Covered first-item anchoring, window edges and all slot update paths:");
      $display("  %0d in-window and %0d ignored requests, %0d deliveries, widest run %0d.",
               in_window_items, ignored_items, deliveries_seen, widest_burst);
      if (mismatches == 0) begin
         $display("** inorder_delivery_reorder_window: PASSED **");
      end else begin
         $display("** inorder_delivery_reorder_window: FAILED **");
      end
      $finish;
   end

endmodule
